@@ rtl/ccwc_pkg.sv @@
// Shared types, constants and the denomination step table of the coin-change way counter.
// No dependencies; all other files refer to this package by scoped names.
`default_nettype none

package ccwc_pkg;

    localparam int unsigned TABLE_ENTRIES = 8192;
    localparam int unsigned IDX_W         = $clog2(TABLE_ENTRIES);
    localparam int unsigned COUNT_W       = 48;
    localparam int unsigned DOLLAR_W      = 10;
    localparam int unsigned CENT_W        = 7;
    localparam int unsigned AMT_W         = 17;   // 1023*100 + 127 fits
    localparam int unsigned UNIT_CENTS    = 5;
    localparam int unsigned REACH         = (TABLE_ENTRIES - 1) * UNIT_CENTS;

    // x / 5 == (x * RECIP) >> RECIP_SHIFT for every x below 81920
    localparam int unsigned RECIP_W       = 16;
    localparam logic [RECIP_W-1:0] RECIP  = 16'hCCCD;
    localparam int unsigned RECIP_SHIFT   = 18;
    localparam int unsigned PROD_W        = AMT_W + RECIP_W;
    localparam int unsigned QUO_W         = PROD_W - RECIP_SHIFT;

    // the 5c pass is folded into the fill (every entry becomes 1)
    localparam int unsigned PASS_COUNT    = 10;
    localparam int unsigned PASS_W        = 4;

    localparam int unsigned QDEPTH        = 4;
    localparam int unsigned QPTR_W        = $clog2(QDEPTH);

    typedef logic [IDX_W-1:0]   idx_t;
    typedef logic [COUNT_W-1:0] count_t;
    typedef logic [AMT_W-1:0]   amount_t;

    typedef struct packed {
        idx_t idx;
        logic oor;
        logic inexact;
    } qentry_t;

    typedef enum logic [1:0] {
        BS_FILL,
        BS_GAP,
        BS_SCAN,
        BS_DONE
    } build_state_t;

    // denomination sizes in 5-cent units, 10c upward
    function automatic logic [31:0] pass_step(input logic [PASS_W-1:0] p);
        logic [31:0] s;
        begin
            case (p)
                4'd0:    s = 32'd2;
                4'd1:    s = 32'd4;
                4'd2:    s = 32'd10;
                4'd3:    s = 32'd20;
                4'd4:    s = 32'd40;
                4'd5:    s = 32'd100;
                4'd6:    s = 32'd200;
                4'd7:    s = 32'd400;
                4'd8:    s = 32'd1000;
                4'd9:    s = 32'd2000;
                default: s = 32'd0;
            endcase
            return s;
        end
    endfunction

endpackage

`default_nettype wire

@@ rtl/coin_change_way_counter.sv @@
// Each query accepted while busy is low returns its result with done high.
// Throughput: one query per cycle once the table is built; the receiver cannot stall.
// After reset busy stays high while the table is built: a fill sweep plus one scan
// per denomination from 10c up, one table entry per cycle.
// Top level: ties the query front end, transaction queue and count table back end.
// Depends on ccwc_pkg, ccwc_front, ccwc_queue, ccwc_back.
`default_nettype none

module coin_change_way_counter (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic [ccwc_pkg::DOLLAR_W-1:0] dollars,
    input  wire logic [ccwc_pkg::CENT_W-1:0]   cents,
    output logic                               done,
    output logic [ccwc_pkg::COUNT_W-1:0]       way_count,
    output logic                               out_of_range
);

    logic                  accept;
    logic                  push;
    ccwc_pkg::qentry_t     push_entry;
    logic                  q_valid;
    ccwc_pkg::qentry_t     q_entry;
    logic                  ready;

    assign busy   = !ready;
    assign accept = start && !busy;

    ccwc_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .dollars (dollars),
        .cents   (cents),
        .push    (push),
        .entry   (push_entry)
    );

    ccwc_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop_ready  (ready),
        .pop_valid  (q_valid),
        .pop_entry  (q_entry)
    );

    ccwc_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_valid),
        .q_entry      (q_entry),
        .ready        (ready),
        .done         (done),
        .way_count    (way_count),
        .out_of_range (out_of_range)
    );

endmodule

`default_nettype wire

@@ rtl/ccwc_front.sv @@
// Query front end: amount conversion, range check and divide-by-five into a table index.
// Depends on ccwc_pkg.
`default_nettype none

module ccwc_front (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          accept,
    input  wire logic [ccwc_pkg::DOLLAR_W-1:0] dollars,
    input  wire logic [ccwc_pkg::CENT_W-1:0]   cents,
    output logic                               push,
    output ccwc_pkg::qentry_t                  entry
);

    logic                              v1_reg;
    ccwc_pkg::amount_t                 amt1_reg;
    logic                              v2_reg;
    ccwc_pkg::amount_t                 amt2_reg;
    logic [ccwc_pkg::QUO_W-1:0]        quo2_reg;
    logic                              oor2_reg;
    logic [ccwc_pkg::PROD_W-1:0]       prod;
    ccwc_pkg::amount_t                 amt1_next;
    ccwc_pkg::amount_t                 back5;

    assign amt1_next = ccwc_pkg::AMT_W'(dollars) * ccwc_pkg::AMT_W'(100)
                     + ccwc_pkg::AMT_W'(cents);
    assign prod = ccwc_pkg::PROD_W'(amt1_reg) * ccwc_pkg::PROD_W'(ccwc_pkg::RECIP);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= accept;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        amt1_reg <= amt1_next;
        amt2_reg <= amt1_reg;
        quo2_reg <= prod[ccwc_pkg::PROD_W-1:ccwc_pkg::RECIP_SHIFT];
        oor2_reg <= 32'(amt1_reg) > ccwc_pkg::REACH;
    end

    // quotient*5 by shift and add; a mismatch means not a multiple of 5 cents
    assign back5 = ccwc_pkg::AMT_W'({quo2_reg, 2'b00}) + ccwc_pkg::AMT_W'(quo2_reg);

    always_comb
    begin
        push          = v2_reg;
        entry.idx     = ccwc_pkg::IDX_W'(quo2_reg);
        entry.oor     = oor2_reg;
        entry.inexact = back5 != amt2_reg;
    end

endmodule

`default_nettype wire

@@ rtl/ccwc_queue.sv @@
// Short transaction queue between the query front end and the table back end.
// Depends on ccwc_pkg.
`default_nettype none

module ccwc_queue (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire ccwc_pkg::qentry_t push_entry,
    input  wire logic              pop_ready,
    output logic                   pop_valid,
    output ccwc_pkg::qentry_t      pop_entry
);

    ccwc_pkg::qentry_t                 slot_reg [ccwc_pkg::QDEPTH];
    logic [ccwc_pkg::QPTR_W-1:0]       wr_ptr_reg;
    logic [ccwc_pkg::QPTR_W-1:0]       rd_ptr_reg;
    logic [ccwc_pkg::QPTR_W:0]         count_reg;
    logic [ccwc_pkg::QPTR_W:0]         count_next;
    logic                              pop;

    assign pop_valid = count_reg != '0;
    assign pop_entry = slot_reg[rd_ptr_reg];
    assign pop       = pop_valid && pop_ready;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push && !pop |-> count_reg < (ccwc_pkg::QPTR_W + 1)'(ccwc_pkg::QDEPTH))
        else $error("query queue overflow");

    a_ptr_track: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg == '0 |-> wr_ptr_reg == rd_ptr_reg)
        else $error("queue pointers disagree with empty count");

endmodule

`default_nettype wire

@@ rtl/ccwc_back.sv @@
// Count table back end: build sequencer for the coin-change table and the query read path.
// Depends on ccwc_pkg; holds the count table memory.
`default_nettype none

module ccwc_back (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              q_valid,
    input  wire ccwc_pkg::qentry_t q_entry,
    output logic                   ready,
    output logic                   done,
    output logic [ccwc_pkg::COUNT_W-1:0] way_count,
    output logic                   out_of_range
);

    localparam ccwc_pkg::idx_t LAST_IDX = ccwc_pkg::IDX_W'(ccwc_pkg::TABLE_ENTRIES - 1);

    ccwc_pkg::count_t              mem [ccwc_pkg::TABLE_ENTRIES];

    ccwc_pkg::build_state_t        state_reg, state_next;
    ccwc_pkg::idx_t                k_reg, k_next;
    logic [ccwc_pkg::PASS_W-1:0]   pass_reg, pass_next;
    logic                          s1_valid_reg, s1_valid_next;
    ccwc_pkg::idx_t                s1_addr_reg;
    ccwc_pkg::count_t              rd_a_reg, rd_b_reg;
    logic                          done_reg;
    logic                          oor_reg;
    logic                          inexact_reg;

    logic [31:0]                   step;
    ccwc_pkg::idx_t                step_idx;
    ccwc_pkg::idx_t                rd_addr_a, rd_addr_b;
    logic                          wr_en;
    ccwc_pkg::idx_t                wr_addr;
    ccwc_pkg::count_t              wr_data;
    logic [ccwc_pkg::COUNT_W:0]    sum;
    logic                          pop;

    assign step     = ccwc_pkg::pass_step(pass_reg);
    assign step_idx = ccwc_pkg::IDX_W'(step);
    assign ready    = state_reg == ccwc_pkg::BS_DONE;
    assign pop      = q_valid && ready;

    assign sum = {1'b0, rd_a_reg} + {1'b0, rd_b_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ccwc_pkg::BS_FILL;
            k_reg        <= '0;
            pass_reg     <= '0;
            s1_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            k_reg        <= k_next;
            pass_reg     <= pass_next;
            s1_valid_reg <= s1_valid_next;
            done_reg     <= pop;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        k_next        = k_reg;
        pass_next     = pass_reg;
        s1_valid_next = 1'b0;
        rd_addr_a     = k_reg;
        rd_addr_b     = k_reg - step_idx;
        wr_en         = 1'b0;
        wr_addr       = s1_addr_reg;
        wr_data       = sum[ccwc_pkg::COUNT_W] ? '1 : sum[ccwc_pkg::COUNT_W-1:0];

        if (s1_valid_reg)
        begin
            wr_en = 1'b1;
        end

        case (state_reg)
            ccwc_pkg::BS_FILL:
            begin
                // one way to make any amount from 5c pieces alone
                wr_en   = 1'b1;
                wr_addr = k_reg;
                wr_data = ccwc_pkg::COUNT_W'(1);
                k_next  = k_reg + 1'b1;
                if (k_reg == LAST_IDX)
                begin
                    state_next = ccwc_pkg::BS_GAP;
                end
            end
            ccwc_pkg::BS_GAP:
            begin
                // the idle gap state lets the previous pass finish its last write
                if (pass_reg == ccwc_pkg::PASS_W'(ccwc_pkg::PASS_COUNT))
                begin
                    state_next = ccwc_pkg::BS_DONE;
                end
                else if (step >= ccwc_pkg::TABLE_ENTRIES)
                begin
                    pass_next = pass_reg + 1'b1;
                end
                else
                begin
                    k_next     = step_idx;
                    state_next = ccwc_pkg::BS_SCAN;
                end
            end
            ccwc_pkg::BS_SCAN:
            begin
                // step >= 2, so the write of entry k-step has landed before this read
                s1_valid_next = 1'b1;
                if (k_reg == LAST_IDX)
                begin
                    pass_next  = pass_reg + 1'b1;
                    state_next = ccwc_pkg::BS_GAP;
                end
                else
                begin
                    k_next = k_reg + 1'b1;
                end
            end
            ccwc_pkg::BS_DONE:
            begin
                rd_addr_a = q_entry.idx;
            end
            default:
            begin
                state_next = ccwc_pkg::BS_FILL;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_a_reg    <= mem[rd_addr_a];
        rd_b_reg    <= mem[rd_addr_b];
        s1_addr_reg <= k_reg;
        oor_reg     <= q_entry.oor;
        inexact_reg <= q_entry.inexact;
    end

    assign done         = done_reg;
    assign out_of_range = oor_reg;
    assign way_count    = (oor_reg || inexact_reg) ? '0 : rd_a_reg;

    a_done_after_build: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> ready)
        else $error("result strobed before table build finished");

    a_build_stays_done: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ccwc_pkg::BS_DONE |=> state_reg == ccwc_pkg::BS_DONE)
        else $error("build sequencer left done state");

    a_no_write_when_ready: assert property (@(posedge clk) disable iff (!rst_n)
        ready |-> !wr_en)
        else $error("table written while serving queries");

    a_oor_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg && out_of_range |-> way_count == '0)
        else $error("nonzero count with out-of-range flag");

endmodule

`default_nettype wire
